[rtl/core/pcs_pkg.sv]
package pcs_pkg;
    localparam int unsigned MAX_POINTS_DEF = 256;
    localparam int unsigned COORD_W = 16;
    localparam int unsigned DIST_W = 17;
    localparam int unsigned D2_W = 33;
    localparam int unsigned CNT_OUT_W = 9;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input item
        logic add;        // append the captured point
        logic walk_clr;   // start a nearest search
        logic walk_step;  // compare one stored point
        logic div_start;  // start root and mean units
        logic div_step;   // one iteration of root and means
        logic out_load;   // load the result register
    } t_cmd;

    typedef struct packed {
        logic walk_done;
        logic iter_done;
    } t_sts;
endpackage

[rtl/core/pcs_ctrl.sv]
module pcs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_fire,
    input  logic          i_cmd_query,
    input  logic          i_out_busy,
    input  pcs_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output pcs_pkg::t_cmd o_cmd
);
    import pcs_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ADD   = 6'b000010,
        S_WALK  = 6'b000100,
        S_START = 6'b001000,
        S_ITER  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    o_cmd.walk_clr = 1'b1;
                    n_state = i_cmd_query ? S_WALK : S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state = S_START;
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_sts.walk_done) n_state = S_START;
            end
            S_START: begin
                o_cmd.div_start = 1'b1;
                n_state = S_ITER;
            end
            S_ITER: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.iter_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

[rtl/core/pcs_datapath.sv]
module pcs_datapath #(
    parameter int unsigned MAX_POINTS = pcs_pkg::MAX_POINTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pcs_pkg::t_cmd                i_cmd,
    input  logic                         i_in_cmd,
    input  logic [pcs_pkg::COORD_W-1:0]  i_in_x,
    input  logic [pcs_pkg::COORD_W-1:0]  i_in_y,
    input  logic                         i_out_ready,
    output pcs_pkg::t_sts                o_sts,
    output logic                         o_out_valid,
    output logic [127:0]                 o_out_data
);
    import pcs_pkg::*;

    localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);
    localparam int unsigned SW = COORD_W + CW;
    localparam int unsigned IT = (SW > D2_W) ? SW : D2_W;
    localparam int unsigned ITW = $clog2(IT + 1);
    localparam int unsigned RIT = (D2_W + 1) / 2;

    logic [2*COORD_W-1:0] r_mem [MAX_POINTS];
    logic [2*COORD_W-1:0] r_rd;
    logic                 r_cmd;
    logic [COORD_W-1:0]   r_px, r_py;
    logic [CW-1:0]        r_cnt;
    logic [SW-1:0]        r_sx, r_sy;
    logic [COORD_W-1:0]   r_lx, r_gx, r_ly, r_gy;
    logic                 r_drop;
    logic [CW-1:0]        r_rptr;
    logic                 r_rvalid;
    logic                 r_dvalid;
    logic [COORD_W-1:0]   r_dx, r_dy;
    logic [D2_W-1:0]      r_best;
    logic                 r_found;
    logic [2*COORD_W-1:0] r_sqx, r_sqy;

    // Walk: address, registered read, abs difference, square, compare.
    wire rd_en = i_cmd.walk_step && (r_rptr < r_cnt);
    always_ff @(posedge i_clk) begin
        if (i_cmd.add && r_cnt < CW'(MAX_POINTS))
            r_mem[r_rptr[AW-1:0]] <= {r_py, r_px};
        if (rd_en) r_rd <= r_mem[r_rptr[AW-1:0]];
    end

    wire [COORD_W-1:0] sx = r_rd[COORD_W-1:0];
    wire [COORD_W-1:0] sy = r_rd[2*COORD_W-1:COORD_W];
    logic r_sqv;
    wire [D2_W-1:0] d2 = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_sx <= '0; r_sy <= '0;
            r_lx <= '1; r_gx <= '0; r_ly <= '1; r_gy <= '0;
            r_rptr <= '0; r_rvalid <= 1'b0; r_dvalid <= 1'b0; r_sqv <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cmd <= i_in_cmd; r_px <= i_in_x; r_py <= i_in_y;
                r_rptr <= i_in_cmd ? '0 : r_cnt;
                r_drop <= 1'b0;
            end
            if (i_cmd.add) begin
                if (r_cnt >= CW'(MAX_POINTS)) begin
                    r_drop <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                    r_sx <= r_sx + SW'(r_px);
                    r_sy <= r_sy + SW'(r_py);
                    if (r_px < r_lx) r_lx <= r_px;
                    if (r_px > r_gx) r_gx <= r_px;
                    if (r_py < r_ly) r_ly <= r_py;
                    if (r_py > r_gy) r_gy <= r_py;
                end
            end
            if (i_cmd.walk_clr) begin
                r_best <= '1; r_found <= 1'b0;
            end
            if (rd_en) r_rptr <= r_rptr + 1'b1;
            r_rvalid <= rd_en;
            r_dvalid <= r_rvalid;
            r_sqv <= r_dvalid;
            if (r_rvalid) begin
                r_dx <= (r_px > sx) ? r_px - sx : sx - r_px;
                r_dy <= (r_py > sy) ? r_py - sy : sy - r_py;
            end
            if (r_dvalid) begin
                r_sqx <= r_dx * r_dx;
                r_sqy <= r_dy * r_dy;
            end
            if (r_sqv) begin
                r_found <= 1'b1;
                if (d2 < r_best) r_best <= d2;
            end
        end
    end
    assign o_sts.walk_done = !rd_en && !r_rvalid && !r_dvalid && !r_sqv;

    // Shared iteration: bit-pair square root and two restoring divides.
    // The root operand is widened to an even number of bits so that every
    // bit pair is consumed exactly once.
    logic [ITW-1:0]  r_it;
    logic [D2_W+1:0] r_rem;
    logic [2*RIT-1:0] r_val;
    logic [DIST_W-1:0] r_root;
    logic [SW-1:0]   r_qx, r_qy;
    logic [CW:0]     r_ax, r_ay;

    wire [D2_W+1:0] trial = {r_rem[D2_W-1:0], r_val[2*RIT-1 -: 2]};
    wire [D2_W+1:0] tsub = {r_root, 2'b01};
    wire [CW:0] tx = {r_ax[CW-1:0], r_qx[SW-1]};
    wire [CW:0] ty = {r_ay[CW-1:0], r_qy[SW-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_it <= '0;
            r_rem <= '0; r_root <= '0;
            r_val <= (r_cmd == CMD_QUERY && r_found) ? {1'b0, r_best} : '0;
            r_qx <= r_sx; r_qy <= r_sy; r_ax <= '0; r_ay <= '0;
        end else if (i_cmd.div_step) begin
            r_it <= r_it + 1'b1;
            if (r_it < ITW'(RIT)) begin
                r_val <= {r_val[2*RIT-3:0], 2'b00};
                if (trial >= tsub) begin
                    r_rem <= trial - tsub;
                    r_root <= {r_root[DIST_W-2:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_root <= {r_root[DIST_W-2:0], 1'b0};
                end
            end
            if (r_it < ITW'(SW)) begin
                if (tx >= {1'b0, r_cnt}) begin
                    r_ax <= tx - {1'b0, r_cnt}; r_qx <= {r_qx[SW-2:0], 1'b1};
                end else begin
                    r_ax <= tx; r_qx <= {r_qx[SW-2:0], 1'b0};
                end
                if (ty >= {1'b0, r_cnt}) begin
                    r_ay <= ty - {1'b0, r_cnt}; r_qy <= {r_qy[SW-2:0], 1'b1};
                end else begin
                    r_ay <= ty; r_qy <= {r_qy[SW-2:0], 1'b0};
                end
            end
        end
    end
    assign o_sts.iter_done = (r_it == ITW'(IT - 1));

    wire emp = (r_cnt == '0);
    wire [CNT_OUT_W+CW-1:0] cnt_ext = {{CNT_OUT_W{1'b0}}, r_cnt};
    wire [DIST_W-1:0] dist_out = (r_cmd == CMD_QUERY && !emp) ? r_root : '0;
    wire [6*COORD_W-1:0] stats_out = emp ? '0 :
        {r_gy, r_ly, r_gx, r_lx, r_qy[COORD_W-1:0], r_qx[COORD_W-1:0]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.out_load) o_out_valid <= 1'b1;
            else if (i_out_ready) o_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            o_out_data <= {4'b0000, stats_out, (r_cmd == CMD_ADD) && r_drop, emp,
                           dist_out, cnt_ext[CNT_OUT_W-1:0]};
        end
    end
endmodule

[rtl/core/point_cluster_stats_unit.sv]
// Point cluster statistics.
// Slave stream: one transfer per item; tuser carries the command (0 add, 1 query)
// and tdata the point. Master stream: one result transfer per item.
// An add loads its result once the shared iteration unit has formed the square
// root and both mean divisions one bit per cycle (33 steps, the larger of the
// squared distance width and 16 + count width).
// A query replaces the add state by a walk over the held points through the
// point memory's single read port; each point read passes the difference,
// square and compare registers before the iteration starts.
// One item is in work at a time; s_tready is high only while the block waits
// for an item, which it does from the cycle its previous result is loaded.
// Reset empties the cluster at once: count, sums and bounds clear, and the
// memory is not swept since only written entries are ever read.
// A result waits in the output register while the receiver stalls; the next
// item may be accepted and worked on, and its result is loaded once the
// register is free.
module point_cluster_stats_unit #(
    parameter int unsigned MAX_POINTS = pcs_pkg::MAX_POINTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,  // x_coord[15:0], y_coord[31:16]
    input  logic         s_tuser,  // command
    output logic         m_tvalid,
    input  logic         m_tready,
    // point_count[8:0], nearest_distance[25:9], cluster_empty[26],
    // add_dropped[27], mean_x[43:28], mean_y[59:44], left_bound[75:60],
    // right_bound[91:76], top_bound[107:92], bottom_bound[123:108]
    output logic [127:0] m_tdata
);
    import pcs_pkg::*;

    t_cmd cmd;
    t_sts sts;
    wire  fire = s_tvalid && s_tready;

    pcs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(fire),
        .i_cmd_query(s_tuser), .i_out_busy(m_tvalid && !m_tready),
        .i_sts(sts), .o_in_ready(s_tready), .o_cmd(cmd)
    );

    pcs_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_in_cmd(s_tuser),
        .i_in_x(s_tdata[15:0]), .i_in_y(s_tdata[31:16]), .i_out_ready(m_tready),
        .o_sts(sts), .o_out_valid(m_tvalid), .o_out_data(m_tdata)
    );
endmodule

[rtl/core/pcs_checker.sv]
module pcs_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while busy");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[26] |-> m_tdata[8:0] == 9'd0 && m_tdata[25:9] == 17'd0)
        else $error("empty cluster with nonzero count or distance");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");
endmodule

bind point_cluster_stats_unit pcs_checker u_pcs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

[tb/tb_point_cluster_stats_unit.sv]
`timescale 1ns / 100ps

module tb_point_cluster_stats_unit;
    import pcs_pkg::*;

    localparam int unsigned CAPACITY   = MAX_POINTS_DEF;
    localparam int          WATCHDOG   = 20000;
    localparam int          N_RANDOM   = 830;

    typedef struct packed {
        logic        cmd;
        logic [15:0] x;
        logic [15:0] y;
    } t_item;

    typedef struct packed {
        logic [15:0] bottom;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] left;
        logic [15:0] mean_y;
        logic [15:0] mean_x;
        logic        dropped;
        logic        empty;
        logic [16:0] near_dist;
        logic [8:0]  count;
    } t_stats;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;   // x_coord[15:0], y_coord[31:16]
    logic         s_tuser = 1'b0; // command
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // point_count, nearest_distance, cluster_empty, add_dropped, mean_x, mean_y,
    // left, right, top, bottom bounds from the lowest bit up
    logic [127:0] m_tdata;

    point_cluster_stats_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state for the cluster.
    logic [31:0] cl_store [CAPACITY];
    int unsigned cl_count;
    longint unsigned cl_sum_x, cl_sum_y;
    logic [15:0] cl_min_x, cl_max_x, cl_min_y, cl_max_y;

    t_item  pending_items[$];
    t_stats expected_stats[$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    bit     hold_off = 1'b0;
    bit     in_accepted = 1'b0;

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_stats cluster_update(t_item it);
        t_stats s;
        longint unsigned best, dx, dy, d2;
        logic [15:0] sx, sy;
        s = '0;
        if (it.cmd == CMD_ADD) begin
            if (cl_count >= CAPACITY) begin
                s.dropped = 1'b1;
            end else begin
                cl_store[cl_count] = {it.y, it.x};
                cl_count++;
                cl_sum_x += it.x;
                cl_sum_y += it.y;
                if (it.x < cl_min_x) cl_min_x = it.x;
                if (it.x > cl_max_x) cl_max_x = it.x;
                if (it.y < cl_min_y) cl_min_y = it.y;
                if (it.y > cl_max_y) cl_max_y = it.y;
            end
        end else if (cl_count != 0) begin
            best = '1;
            for (int i = 0; i < cl_count; i++) begin
                sx = cl_store[i][15:0];
                sy = cl_store[i][31:16];
                dx = it.x > sx ? it.x - sx : sx - it.x;
                dy = it.y > sy ? it.y - sy : sy - it.y;
                d2 = dx * dx + dy * dy;
                if (d2 < best) best = d2;
            end
            s.near_dist = 17'(floor_root(best));
        end
        s.count = 9'(cl_count);
        s.empty = (cl_count == 0);
        if (cl_count != 0) begin
            s.mean_x = 16'(cl_sum_x / cl_count);
            s.mean_y = 16'(cl_sum_y / cl_count);
            s.left   = cl_min_x;
            s.right  = cl_max_x;
            s.top    = cl_min_y;
            s.bottom = cl_max_y;
        end
        return s;
    endfunction

    function automatic t_item mk(logic cmd, logic [15:0] x, logic [15:0] y);
        t_item it;
        it.cmd = cmd; it.x = x; it.y = y;
        return it;
    endfunction

    function automatic void queue_item(t_item it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            3: return 16'($urandom_range(65280, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    // Remembers whether the offered item was transferred at the last rising edge.
    always @(posedge i_clk) begin
        in_accepted <= s_tvalid && s_tready;
    end

    // Driver: presents items from the queue with random gaps.
    int drive_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && !in_accepted) begin
                // hold the item until transferred
            end else if (drive_gap > 0) begin
                drive_gap <= drive_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                s_tuser  <= pending_items[0].cmd;
                s_tdata  <= {pending_items[0].y, pending_items[0].x};
                s_tvalid <= 1'b1;
                void'(pending_items.pop_front());
                if ($urandom_range(0, 3) == 0)
                    drive_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400)
                                                             : $urandom_range(1, 3);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver readiness: random stalls, plus a long forced hold-off.
    int stall = 0;
    always @(negedge i_clk) begin
        if (hold_off) begin
            m_tready <= 1'b0;
        end else if (stall > 0) begin
            stall <= stall - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400)
                                                 : $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: predict on input transfers, compare on output transfers.
    always @(posedge i_clk) begin
        t_stats got, want;
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (s_tvalid && s_tready)
                expected_stats.insert(expected_stats.size(),
                                      cluster_update(mk(s_tuser, s_tdata[15:0],
                                                        s_tdata[31:16])));
            if (m_tvalid && m_tready) begin
                got = t_stats'(m_tdata[123:0]);
                if (expected_stats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer %h", got);
                end else begin
                    want = expected_stats.pop_front();
                    if (got !== want || m_tdata[127:124] !== 4'b0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p\n          actual   %p",
                                     want, got);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG) begin
                $display("[point_cluster_stats_unit] ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_item it;
        cl_count = 0; cl_sum_x = 0; cl_sum_y = 0;
        cl_min_x = '1; cl_max_x = '0; cl_min_y = '1; cl_max_y = '0;

        // Directed: queries on an empty cluster, then adds and queries at field extremes.
        queue_item(mk(CMD_QUERY, 16'h0000, 16'h0000));
        queue_item(mk(CMD_QUERY, 16'hFFFF, 16'hFFFF));
        queue_item(mk(CMD_ADD,   16'h0000, 16'h0000));
        queue_item(mk(CMD_QUERY, 16'hFFFF, 16'hFFFF));
        queue_item(mk(CMD_ADD,   16'hFFFF, 16'hFFFF));
        queue_item(mk(CMD_QUERY, 16'h0000, 16'hFFFF));
        queue_item(mk(CMD_ADD,   16'h5555, 16'hAAAA));
        queue_item(mk(CMD_QUERY, 16'h5555, 16'hAAAA));
        queue_item(mk(CMD_ADD,   16'hAAAA, 16'h5555));
        queue_item(mk(CMD_QUERY, 16'h8000, 16'h7FFF));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Receiver holds off while the sender keeps offering items.
        hold_off = 1'b1;
        repeat (600) @(posedge i_clk);
        hold_off = 1'b0;
        wait (pending_items.size() == 0 && expected_stats.size() == 0);

        // Fill the store with a mix of queries, then push beyond capacity.
        for (int i = 0; i < N_RANDOM; i++) begin
            it.cmd = ($urandom_range(0, 99) < 45) ? CMD_QUERY : CMD_ADD;
            it.x = rand_coord();
            it.y = rand_coord();
            queue_item(it);
        end
        wait (pending_items.size() == 0 && !s_tvalid && expected_stats.size() == 0);
        repeat (400) @(posedge i_clk);
        if (mismatches == 0 && expected_stats.size() == 0)
            $display("[point_cluster_stats_unit] OK");
        else
            $display("[point_cluster_stats_unit] ERROR");
        $finish;
    end
endmodule
